[src/csp_pkg.sv]
package csp_pkg;

    localparam int DIV_W          = 32;
    localparam int CAP_W          = 16;
    localparam int FREQ_W         = 24;
    localparam int PCT_W          = 8;
    localparam int OUT_DATA_W     = 80;

    localparam logic [FREQ_W-1:0] NUMERATOR_RESET = 24'd1020833;
    localparam logic [6:0]        PCT_SCALE       = 7'd100;
    localparam logic [PCT_W-1:0]  PCT_MAX         = 8'hFF;
    localparam logic [CAP_W-1:0]  WRAP_MAX        = 16'hFFFF;

    localparam logic [1:0] OP_OVERFLOW = 2'd0;
    localparam logic [1:0] OP_CAPTURE  = 2'd1;
    localparam logic [1:0] OP_SAMPLE   = 2'd2;

    localparam logic [1:0] FILTER_RED   = 2'd0;
    localparam logic [1:0] FILTER_BLUE  = 2'd1;
    localparam logic [1:0] FILTER_CLEAR = 2'd2;
    localparam logic [1:0] FILTER_GREEN = 2'd3;

endpackage

[src/csp_div.sv]
// Restoring divider, one quotient bit per cycle.
module csp_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [csp_pkg::DIV_W-1:0]  dividend,
    input  logic [csp_pkg::DIV_W-1:0]  divisor,
    output logic                       busy,
    output logic                       done,
    output logic [csp_pkg::DIV_W-1:0]  quotient
);
    import csp_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

    logic [CNT_W-1:0] count_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] dvs_reg;

    logic [DIV_W+1:0] trial;
    logic             q_bit;
    logic [DIV_W-1:0] rem_next;

    always_comb begin
        trial = {1'b0, rem_reg, quo_reg[DIV_W-1]} - {2'b00, dvs_reg};
        q_bit = !trial[DIV_W+1];
        if (q_bit) begin
            rem_next = trial[DIV_W-1:0];
        end else begin
            rem_next = {rem_reg[DIV_W-2:0], quo_reg[DIV_W-1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            done_reg <= busy_reg && (count_reg == CNT_LAST);
            if (busy_reg) begin
                count_reg <= count_reg + 1'b1;
                if (count_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                end
            end else if (start) begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIV_W-2:0], q_bit};
        end else if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[src/color_sensor_period_ratio.sv]
// Channel  | Handshake                | Payload
// s_       | s_tvalid / s_tready      | s_tdata: capture_value; s_tuser: operation
// m_       | m_tvalid / m_tready      | m_tdata: filter_code .. clear_freq;
//          |                          | m_tlast: round_done; m_tuser: div_error
// cfg_     | cfg_wr_en                | cfg_wr_data: clock_numerator
//
// Overflow and capture words are taken in S_IDLE without the divider. A sample
// word takes one pass of the shared bit-serial divider, and the green sample
// that closes a round takes four divider passes.
// Reset is synchronous, active low; the numerator returns to its default.
// s_tready is low while a sample is worked on; a result held by a stalled
// m_ side blocks only the next sample from finishing.
module color_sensor_period_ratio (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [15:0]                      s_tdata,   // [15:0] capture_value
    input  logic [1:0]                       s_tuser,   // [1:0] operation
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [1:0] filter_code, [25:2] channel_freq, [33:26] red_pct, [41:34] green_pct,
    // [49:42] blue_pct, [73:50] clear_freq, [79:74] zero
    output logic [csp_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                             m_tlast,   // round_done
    output logic                             m_tuser,   // div_error
    input  logic                             cfg_wr_en,
    input  logic [csp_pkg::FREQ_W-1:0]       cfg_wr_data
);
    import csp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_FREQ = 4'b0010,
        S_PCT  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t            state_reg;
    logic [FREQ_W-1:0] numer_reg;
    logic [CAP_W-1:0]  wrap_reg;
    logic [CAP_W-1:0]  last_cap_reg;
    logic [DIV_W-1:0]  period_reg;
    logic [1:0]        filter_reg;
    logic [FREQ_W-1:0] store_reg [3];
    logic [FREQ_W-1:0] freq_reg;
    logic              err_reg;
    logic [1:0]        pct_idx_reg;
    logic [PCT_W-1:0]  pct_reg [3];

    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic                  m_tlast_reg;
    logic                  m_tuser_reg;

    logic              in_acc;
    logic              div_start;
    logic              div_busy;
    logic              div_done;
    logic [DIV_W-1:0]  div_quo;
    logic [DIV_W-1:0]  div_dividend;
    logic [DIV_W-1:0]  div_divisor;
    logic [1:0]        pct_sel;
    logic [FREQ_W-1:0] sel_chan;
    logic [30:0]       scaled_chan;
    logic [FREQ_W-1:0] freq_next;
    logic [PCT_W-1:0]  pct_next;
    logic              round_end;
    logic              clear_zero;
    logic              out_free;
    logic [PCT_W-1:0]  red_o, green_o, blue_o;
    logic [FREQ_W-1:0] clear_o;

    assign s_tready   = (state_reg == S_IDLE);
    assign in_acc     = s_tvalid && s_tready;
    assign round_end  = (filter_reg == FILTER_GREEN);
    assign clear_zero = (store_reg[2] == '0);
    assign out_free   = !m_tvalid_reg || m_tready;

    // red, green (just measured), blue
    always_comb begin
        pct_sel = (state_reg == S_PCT) ? pct_idx_reg + 2'd1 : 2'd0;
        case (pct_sel)
            2'd0:    sel_chan = store_reg[0];
            2'd1:    sel_chan = freq_reg;
            default: sel_chan = store_reg[1];
        endcase
        scaled_chan = 31'(sel_chan) * 31'(PCT_SCALE);
        if (state_reg == S_IDLE) begin
            div_dividend = DIV_W'(numer_reg);
            div_divisor  = period_reg;
        end else begin
            div_dividend = DIV_W'(scaled_chan);
            div_divisor  = DIV_W'(store_reg[2]);
        end
        div_start = (in_acc && s_tuser == OP_SAMPLE)
                 || (state_reg == S_FREQ && div_done && round_end)
                 || (state_reg == S_PCT && div_done && pct_idx_reg != 2'd2);
        freq_next = (period_reg == '0) ? '0 : div_quo[FREQ_W-1:0];
        pct_next  = (div_quo[DIV_W-1:PCT_W] != '0) ? PCT_MAX : div_quo[PCT_W-1:0];
    end

    csp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            numer_reg    <= NUMERATOR_RESET;
            wrap_reg     <= '0;
            last_cap_reg <= '0;
            period_reg   <= '0;
            filter_reg   <= FILTER_RED;
            store_reg[0] <= '0;
            store_reg[1] <= '0;
            store_reg[2] <= '0;
            pct_idx_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                numer_reg <= cfg_wr_data;
            end
            if (state_reg == S_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (in_acc) begin
                        case (s_tuser)
                            OP_OVERFLOW: begin
                                if (wrap_reg != WRAP_MAX) begin
                                    wrap_reg <= wrap_reg + 1'b1;
                                end
                            end
                            OP_CAPTURE: begin
                                period_reg   <= {wrap_reg, s_tdata - last_cap_reg};
                                last_cap_reg <= s_tdata;
                                wrap_reg     <= '0;
                            end
                            OP_SAMPLE: state_reg <= S_FREQ;
                            default: ;
                        endcase
                    end
                end
                S_FREQ: begin
                    if (div_done) begin
                        freq_reg <= freq_next;
                        err_reg  <= (period_reg == '0) || (round_end && clear_zero);
                        if (round_end) begin
                            pct_idx_reg <= '0;
                            state_reg   <= S_PCT;
                        end else begin
                            store_reg[filter_reg] <= freq_next;
                            state_reg             <= S_OUT;
                        end
                    end
                end
                S_PCT: begin
                    if (div_done) begin
                        pct_reg[pct_idx_reg] <= pct_next;
                        pct_idx_reg          <= pct_idx_reg + 2'd1;
                        if (pct_idx_reg == 2'd2) begin
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        filter_reg <= filter_reg + 2'd1;
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        if (round_end && !clear_zero) begin
            red_o   = pct_reg[0];
            green_o = pct_reg[1];
            blue_o  = pct_reg[2];
        end else begin
            red_o   = '0;
            green_o = '0;
            blue_o  = '0;
        end
        clear_o = round_end ? store_reg[2] : '0;
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_OUT && out_free) begin
            m_tdata_reg <= {6'b0, clear_o, blue_o, green_o, red_o, freq_reg,
                            filter_reg + 2'd1};
            m_tlast_reg <= round_end;
            m_tuser_reg <= err_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    a_ready_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_busy)
        else $error("input ready while divider busy");

    a_done_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_FREQ || state_reg == S_PCT))
        else $error("divider result outside a sample");

    a_round_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[1:0] == FILTER_RED)
        else $error("round end without filter wrap to red");

    a_err_zero_freq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast && m_tuser |-> m_tdata[25:2] == '0)
        else $error("zero period gave nonzero frequency");

endmodule
